// ----- rtl/atrp_pkg.sv -----
package atrp_pkg;

   // Field widths
   localparam int IN_W      = 16;
   localparam int ROLL_W    = 16;
   localparam int PITCH_W   = 15;

   // CORDIC datapath: operands are counts times 2^8, angle is degrees times 2^20
   localparam int OPND_SHIFT = 8;
   localparam int ACC_FRAC   = 20;
   localparam int TABLE_LEN  = 24;
   localparam int VEC_W      = 28;
   localparam int ANG_W      = 30;

   // Square root: radicand is (y*y + z*z) * 2^16, one result bit per cell
   localparam int SQ_W       = 32;
   localparam int RAD_W      = 48;
   localparam int SQRT_STEPS = 24;
   localparam int MAG_W      = 24;

   localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(90 * (1 << ACC_FRAC));

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] ang;
      logic                    zero;
   } cordic_type;

   typedef struct packed {
      logic [RAD_W-1:0]        rem;
      logic [RAD_W-1:0]        root;
      logic signed [IN_W-1:0]  ax;
      logic signed [IN_W-1:0]  ay;
      logic signed [IN_W-1:0]  az;
   } sqrt_type;

   // atan(2^-i) in degrees times 2^20, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0:       val = ANG_W'(47185920);
         1:       val = ANG_W'(27855475);
         2:       val = ANG_W'(14718068);
         3:       val = ANG_W'(7471121);
         4:       val = ANG_W'(3750058);
         5:       val = ANG_W'(1876857);
         6:       val = ANG_W'(938658);
         7:       val = ANG_W'(469357);
         8:       val = ANG_W'(234682);
         9:       val = ANG_W'(117342);
         10:      val = ANG_W'(58671);
         11:      val = ANG_W'(29335);
         12:      val = ANG_W'(14668);
         13:      val = ANG_W'(7334);
         14:      val = ANG_W'(3667);
         15:      val = ANG_W'(1833);
         16:      val = ANG_W'(917);
         17:      val = ANG_W'(458);
         18:      val = ANG_W'(229);
         19:      val = ANG_W'(115);
         20:      val = ANG_W'(57);
         21:      val = ANG_W'(29);
         22:      val = ANG_W'(14);
         23:      val = ANG_W'(7);
         default: val = '0;
      endcase
      return val;
   endfunction

   // Flag the all-zero vector and fold the left half plane by +-90 degrees
   function automatic cordic_type cordic_prep(input logic signed [VEC_W-1:0] xv,
                                              input logic signed [VEC_W-1:0] yv);
      cordic_type v;
      v.zero = (xv == '0) && (yv == '0);
      v.x    = xv;
      v.y    = yv;
      v.ang  = '0;
      if (xv < 0) begin
         if (yv >= 0) begin
            v.x   = yv;
            v.y   = -xv;
            v.ang = ANG_90;
         end else begin
            v.x   = -yv;
            v.y   = xv;
            v.ang = -ANG_90;
         end
      end
      return v;
   endfunction

   // One vectoring micro-rotation, steering y toward zero
   function automatic cordic_type cordic_rotate(input cordic_type v, input int idx);
      cordic_type o;
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      dx     = v.y >>> idx;
      dy     = v.x >>> idx;
      o.zero = v.zero;
      if (v.y >= 0) begin
         o.x   = v.x + dx;
         o.y   = v.y - dy;
         o.ang = v.ang + atan_entry(idx);
      end else begin
         o.x   = v.x - dx;
         o.y   = v.y + dy;
         o.ang = v.ang - atan_entry(idx);
      end
      return o;
   endfunction

endpackage

// ----- rtl/atrp_sqrt_cell.sv -----
module atrp_sqrt_cell import atrp_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     valid_in,
   input  sqrt_type sqrt_in,
   output logic     valid_out,
   output sqrt_type sqrt_out
);

   localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

   logic     valid_ff;
   sqrt_type data_ff;
   sqrt_type data_in;
   logic [RAD_W-1:0] trial;

   // Decide one root bit: subtract the trial value when it fits
   always_comb begin
      trial   = sqrt_in.root + BIT;
      data_in = sqrt_in;
      if (sqrt_in.rem >= trial) begin
         data_in.rem  = sqrt_in.rem - trial;
         data_in.root = (sqrt_in.root >> 1) + BIT;
      end else begin
         data_in.root = sqrt_in.root >> 1;
      end
   end

   // Advance the item to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_out = valid_ff;
   assign sqrt_out  = data_ff;

endmodule

// ----- rtl/atrp_cordic_cell.sv -----
module atrp_cordic_cell import atrp_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       valid_in,
   input  cordic_type roll_in,
   input  cordic_type pitch_in,
   output logic       valid_out,
   output cordic_type roll_out,
   output cordic_type pitch_out
);

   logic       valid_ff;
   cordic_type roll_ff;
   cordic_type pitch_ff;
   cordic_type roll_in_v;
   cordic_type pitch_in_v;

   // Rotate both vectors by this cell's fixed angle
   always_comb begin
      roll_in_v  = cordic_rotate(roll_in, STEP);
      pitch_in_v = cordic_rotate(pitch_in, STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff  <= roll_in_v;
      pitch_ff <= pitch_in_v;
   end

   assign valid_out = valid_ff;
   assign roll_out  = roll_ff;
   assign pitch_out = pitch_ff;

endmodule

// ----- rtl/accel_tilt_roll_pitch_unit.sv -----
// Roll and pitch from one raw three-axis accelerometer sample: roll = atan2(y, z),
// pitch = atan2(-x, sqrt(y*y + z*z)), both in signed degrees with ANGLE_FRAC_BITS
// fractional bits. The unit is a fixed pipeline: busy never rises, a sample may be
// started in every cycle, and its result appears on rsp_valid after passing through
// the squaring and summing stages, 24 cells of the bit-per-cell square root, one fold
// stage, one CORDIC cell per stage and one rounding stage, in that order.
// Results are shown for a single cycle and cannot be held off, so the receiver must
// take each one when it appears.
module accel_tilt_roll_pitch_unit import atrp_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [IN_W-1:0]    req_accel_x,
   input  logic signed [IN_W-1:0]    req_accel_y,
   input  logic signed [IN_W-1:0]    req_accel_z,
   output logic                      rsp_valid,
   output logic signed [ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle
);

   localparam int NUM_STAGES = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
   localparam int RND_SH     = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [ANG_W:0] RND_HALF  = (ANG_W+1)'(1) <<< (RND_SH - 1);
   localparam logic signed [ANG_W:0] ROLL_LIM  = (ANG_W+1)'(180 * (1 << ANGLE_FRAC_BITS));
   localparam logic signed [ANG_W:0] PITCH_LIM = (ANG_W+1)'(90 * (1 << ANGLE_FRAC_BITS));

   logic accept;

   // Squaring stage
   logic                   mul_valid_ff;
   logic signed [SQ_W-1:0] ysq_ff;
   logic signed [SQ_W-1:0] zsq_ff;
   logic signed [SQ_W-1:0] ysq_in;
   logic signed [SQ_W-1:0] zsq_in;
   logic signed [IN_W-1:0] ax_ff;
   logic signed [IN_W-1:0] ay_ff;
   logic signed [IN_W-1:0] az_ff;

   // Summing stage
   logic             sum_valid_ff;
   sqrt_type         sum_ff;
   sqrt_type         sum_in;
   logic [SQ_W-1:0]  sq_sum;

   // Square root chain
   logic     sqrt_valid [0:SQRT_STEPS];
   sqrt_type sqrt_data  [0:SQRT_STEPS];

   // Fold stage
   logic       prep_valid_ff;
   cordic_type roll_prep_ff;
   cordic_type pitch_prep_ff;
   cordic_type roll_prep_in;
   cordic_type pitch_prep_in;
   logic signed [VEC_W-1:0] roll_x;
   logic signed [VEC_W-1:0] roll_y;
   logic signed [VEC_W-1:0] pitch_x;
   logic signed [VEC_W-1:0] pitch_y;
   logic signed [VEC_W-1:0] ax_ext;

   // CORDIC chain
   logic       cordic_valid [0:NUM_STAGES];
   cordic_type roll_vec     [0:NUM_STAGES];
   cordic_type pitch_vec    [0:NUM_STAGES];

   // Output stage
   logic                      rsp_valid_ff;
   logic signed [ROLL_W-1:0]  rsp_roll_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic signed [ROLL_W-1:0]  rsp_roll_in;
   logic signed [PITCH_W-1:0] rsp_pitch_in;
   logic signed [ANG_W:0]     roll_rnd;
   logic signed [ANG_W:0]     pitch_rnd;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Square y and z, hold the raw sample alongside
   assign ysq_in = req_accel_y * req_accel_y;
   assign zsq_in = req_accel_z * req_accel_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      ysq_ff <= ysq_in;
      zsq_ff <= zsq_in;
      ax_ff  <= req_accel_x;
      ay_ff  <= req_accel_y;
      az_ff  <= req_accel_z;
   end

   // Form the radicand (y*y + z*z) * 2^16 and start the root at zero
   always_comb begin
      sq_sum      = ysq_ff + zsq_ff;
      sum_in.rem  = {sq_sum, (RAD_W-SQ_W)'(0)};
      sum_in.root = '0;
      sum_in.ax   = ax_ff;
      sum_in.ay   = ay_ff;
      sum_in.az   = az_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // Square root, one result bit per cell
   assign sqrt_valid[0] = sum_valid_ff;
   assign sqrt_data[0]  = sum_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      atrp_sqrt_cell #(
         .STEP (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (sqrt_valid[k]),
         .sqrt_in   (sqrt_data[k]),
         .valid_out (sqrt_valid[k+1]),
         .sqrt_out  (sqrt_data[k+1])
      );
   end

   // Scale operands by 2^8, negate x in full width, fold both vectors
   always_comb begin
      roll_x  = VEC_W'(sqrt_data[SQRT_STEPS].az) <<< OPND_SHIFT;
      roll_y  = VEC_W'(sqrt_data[SQRT_STEPS].ay) <<< OPND_SHIFT;
      ax_ext  = VEC_W'(sqrt_data[SQRT_STEPS].ax);
      pitch_y = (-ax_ext) <<< OPND_SHIFT;
      pitch_x = $signed(VEC_W'(sqrt_data[SQRT_STEPS].root[MAG_W-1:0]));
      roll_prep_in  = cordic_prep(roll_x, roll_y);
      pitch_prep_in = cordic_prep(pitch_x, pitch_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= sqrt_valid[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      roll_prep_ff  <= roll_prep_in;
      pitch_prep_ff <= pitch_prep_in;
   end

   // CORDIC vectoring, one micro-rotation per cell
   assign cordic_valid[0] = prep_valid_ff;
   assign roll_vec[0]     = roll_prep_ff;
   assign pitch_vec[0]    = pitch_prep_ff;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cordic
      atrp_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (cordic_valid[i]),
         .roll_in   (roll_vec[i]),
         .pitch_in  (pitch_vec[i]),
         .valid_out (cordic_valid[i+1]),
         .roll_out  (roll_vec[i+1]),
         .pitch_out (pitch_vec[i+1])
      );
   end

   // Round half up, clamp, drop angles of the zero vector, wrap to field width
   always_comb begin
      roll_rnd  = ((ANG_W+1)'(roll_vec[NUM_STAGES].ang) + RND_HALF) >>> RND_SH;
      pitch_rnd = ((ANG_W+1)'(pitch_vec[NUM_STAGES].ang) + RND_HALF) >>> RND_SH;
      if (roll_rnd > ROLL_LIM) begin
         roll_rnd = ROLL_LIM;
      end else if (roll_rnd < -ROLL_LIM) begin
         roll_rnd = -ROLL_LIM;
      end
      if (pitch_rnd > PITCH_LIM) begin
         pitch_rnd = PITCH_LIM;
      end else if (pitch_rnd < -PITCH_LIM) begin
         pitch_rnd = -PITCH_LIM;
      end
      if (roll_vec[NUM_STAGES].zero) begin
         roll_rnd = '0;
      end
      if (pitch_vec[NUM_STAGES].zero) begin
         pitch_rnd = '0;
      end
      rsp_roll_in  = roll_rnd[ROLL_W-1:0];
      rsp_pitch_in = pitch_rnd[PITCH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cordic_valid[NUM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_roll_ff  <= rsp_roll_in;
      rsp_pitch_ff <= rsp_pitch_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;

endmodule
